// ===== src/hwpa_pkg.sv =====
// Shared types and constants for the half-wave period analyzer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package hwpa_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned MagW    = 16;
  localparam int unsigned SqW     = 31;
  localparam int unsigned FloorW  = 15;
  localparam int unsigned BlkLenW = 16;
  localparam int unsigned LenW    = 24;
  localparam int unsigned SumW    = 54;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [FloorW-1:0]  NoiseFloorRst  = 15'd1;
  localparam logic [BlkLenW-1:0] BlockLengthRst = 16'd1024;

  // two's complement polarity code
  typedef enum logic [1:0] {
    CLS_ZERO = 2'b00,
    CLS_POS  = 2'b01,
    CLS_NEG  = 2'b11
  } cls_e;

  typedef enum logic [0:0] {
    REG_NOISE_FLOOR  = 1'b0,
    REG_BLOCK_LENGTH = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    cls_e              cls;
    logic [MagW-1:0]   mag;
    logic [SqW-1:0]    sq;
    logic              blk;
  } smp_t;

  typedef struct packed {
    cls_e              polarity;
    logic [LenW-1:0]   length;
    logic [MagW-1:0]   peak;
    logic [SumW-1:0]   sum;
  } res_t;

endpackage

// ===== src/hwpa_cfg.sv =====
// APB register file: noise_floor and block_length.
// Depends on hwpa_pkg.
`timescale 1ns / 1ps

module hwpa_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [hwpa_pkg::CfgAddrW-1:0]    paddr_i,
  input  logic [hwpa_pkg::CfgDataW-1:0]    pwdata_i,
  output logic [hwpa_pkg::CfgDataW-1:0]    prdata_o,
  output logic [hwpa_pkg::FloorW-1:0]      floor_o,
  output logic [hwpa_pkg::BlkLenW-1:0]     blk_len_o
);

  logic                          wr_en;
  hwpa_pkg::cfg_reg_e            reg_sel;
  logic [hwpa_pkg::FloorW-1:0]   floor_q;
  logic [hwpa_pkg::BlkLenW-1:0]  blk_len_q;

  assign wr_en   = psel_i & penable_i & pwrite_i;
  assign reg_sel = hwpa_pkg::cfg_reg_e'(paddr_i[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q   <= hwpa_pkg::NoiseFloorRst;
      blk_len_q <= hwpa_pkg::BlockLengthRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        hwpa_pkg::REG_NOISE_FLOOR:  floor_q   <= pwdata_i[hwpa_pkg::FloorW-1:0];
        hwpa_pkg::REG_BLOCK_LENGTH: blk_len_q <= pwdata_i[hwpa_pkg::BlkLenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (reg_sel)
      hwpa_pkg::REG_NOISE_FLOOR:  prdata_o = {17'd0, floor_q};
      hwpa_pkg::REG_BLOCK_LENGTH: prdata_o = {16'd0, blk_len_q};
      default: prdata_o = '0;
    endcase
  end

  assign floor_o   = floor_q;
  assign blk_len_o = blk_len_q;

endmodule

// ===== src/hwpa_front.sv =====
// Input stage: registers a sample, its class, magnitude and square.
// Depends on hwpa_pkg.
`timescale 1ns / 1ps

module hwpa_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [hwpa_pkg::SampleW-1:0] sample_i,
  input  logic                               blk_i,
  input  logic [hwpa_pkg::FloorW-1:0]        floor_i,
  input  logic                               down_free_i,
  output logic                               smp_valid_o,
  output hwpa_pkg::smp_t                     smp_o
);

  logic                              valid_q, valid_d;
  hwpa_pkg::smp_t                    smp_q, smp_d;
  logic                              accept;
  logic signed [hwpa_pkg::SampleW:0] s_ext, f_ext, s_plus_f, s_abs;
  logic [2*hwpa_pkg::MagW-1:0]       sq_full;

  assign in_ready_o = !valid_q || down_free_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s_ext    = {sample_i[hwpa_pkg::SampleW-1], sample_i};
    f_ext    = $signed({2'b00, floor_i});
    s_plus_f = s_ext + f_ext;
    s_abs    = sample_i[hwpa_pkg::SampleW-1] ? -s_ext : s_ext;
    smp_d.mag = s_abs[hwpa_pkg::MagW-1:0];
    sq_full   = smp_d.mag * smp_d.mag;
    smp_d.sq  = sq_full[hwpa_pkg::SqW-1:0];
    smp_d.blk = blk_i;
    priority if (s_ext > f_ext) begin
      smp_d.cls = hwpa_pkg::CLS_POS;
    end else if (s_plus_f[hwpa_pkg::SampleW]) begin
      smp_d.cls = hwpa_pkg::CLS_NEG;
    end else begin
      smp_d.cls = hwpa_pkg::CLS_ZERO;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (down_free_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= smp_d;
    end
  end

  assign smp_valid_o = valid_q;
  assign smp_o       = smp_q;

endmodule

// ===== src/hwpa_core.sv =====
// Period state: tracks class, length, peak and square sum; emits periods.
// Depends on hwpa_pkg; fed by hwpa_front.
`timescale 1ns / 1ps

module hwpa_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           smp_valid_i,
  input  hwpa_pkg::smp_t                 smp_i,
  input  logic [hwpa_pkg::FloorW-1:0]    floor_i,
  input  logic [hwpa_pkg::BlkLenW-1:0]   blk_len_i,
  output logic                           free_o,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output hwpa_pkg::res_t                 res_o
);

  logic                          started_q;
  hwpa_pkg::cls_e                cls_q;
  logic [hwpa_pkg::LenW-1:0]     len_q, len_d, len_base;
  logic [hwpa_pkg::MagW-1:0]     peak_q, peak_d, peak_base;
  logic [hwpa_pkg::SumW-1:0]     sum_q, sum_d, sum_base;
  logic [hwpa_pkg::SumW:0]       sum_ext;
  logic                          out_valid_q, out_valid_d;
  hwpa_pkg::res_t                res_q;
  hwpa_pkg::cls_e                cur_cls;
  logic                          consume, changed, split, emit;

  assign free_o  = !out_valid_q || res_ready_i;
  assign consume = smp_valid_i && free_o;

  always_comb begin
    cur_cls = started_q ? cls_q : smp_i.cls;
    changed = (cur_cls != smp_i.cls);
    split   = smp_i.blk && (cur_cls == hwpa_pkg::CLS_ZERO) && (len_q >= {8'd0, blk_len_i});
    emit    = (changed || split) && ((peak_q >= {1'b0, floor_i}) || split);

    len_base  = emit ? '0 : len_q;
    peak_base = (emit && changed) ? '0 : peak_q;
    sum_base  = (emit && changed) ? '0 : sum_q;

    sum_ext = {1'b0, sum_base} + {24'd0, smp_i.sq};
    if (smp_i.cls != hwpa_pkg::CLS_ZERO) begin
      peak_d = (smp_i.mag > peak_base) ? smp_i.mag : peak_base;
      sum_d  = sum_ext[hwpa_pkg::SumW] ? '1 : sum_ext[hwpa_pkg::SumW-1:0];
    end else begin
      peak_d = {1'b0, floor_i};
      sum_d  = sum_base;
    end
    len_d = (&len_base) ? len_base : len_base + 1'b1;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (consume) begin
      out_valid_d = emit;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      cls_q       <= hwpa_pkg::CLS_ZERO;
      len_q       <= '0;
      peak_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (consume) begin
        started_q <= 1'b1;
        cls_q     <= smp_i.cls;
        len_q     <= len_d;
        peak_q    <= peak_d;
        sum_q     <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && emit) begin
      res_q.polarity <= cur_cls;
      res_q.length   <= len_q;
      res_q.peak     <= peak_q;
      res_q.sum      <= sum_q;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(started_q) |-> started_q)
    else $error("started flag dropped");

  a_zero_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && smp_i.cls == hwpa_pkg::CLS_ZERO) |=> (peak_q == {1'b0, $past(floor_i)}))
    else $error("near-zero sample did not set peak to floor");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume |=> (len_q != '0))
    else $error("period length zero after a sample");

  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(consume && emit))
    else $error("result appeared without an emitting sample");
`endif

endmodule

// ===== src/half_wave_period_analyzer.sv =====
// Top level of the half-wave period analyzer: APB config, input stage, period state.
// Depends on hwpa_pkg, hwpa_cfg, hwpa_front and hwpa_core.
//
// Usage: samples enter on the s_axis channel (tdata = Q15 sample, tuser =
// block_start). Finished periods leave on m_axis (tuser = polarity, tdata =
// length, peak, square sum). At most one result transaction per sample.
// A sample accepted on s_axis is registered in the input stage, then updates
// the period state once that is free; a period it closes is presented on m_axis from that update on.
// Throughput: one sample per cycle while m_axis is not stalled, set by the
// class/accumulate update that closes on the period state registers.
// A stalled m_axis holds its result and freezes the period state; the input
// stage holds at most one sample behind it, so s_axis_tready is low while
// both are occupied and rises in the cycle m_axis_tready returns.
// Reset clears the period state, puts noise_floor to 1 and block_length to
// 1024; the first sample after reset starts the period with its own class.
// The user must write registers over APB only while the stream is idle; the block does not enforce it.
`timescale 1ns / 1ps

module half_wave_period_analyzer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic [0:0]  s_axis_tuser,   // [0] block_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [23:0] period_length, [39:24] period_peak,
                                      // [93:40] square_sum, [95:94] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] period_polarity
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [hwpa_pkg::FloorW-1:0]  floor;
  logic [hwpa_pkg::BlkLenW-1:0] blk_len;
  logic                         smp_valid;
  hwpa_pkg::smp_t               smp;
  logic                         core_free;
  hwpa_pkg::res_t               res;

  assign pready = 1'b1;

  hwpa_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .floor_o   (floor),
    .blk_len_o (blk_len)
  );

  hwpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    ($signed(s_axis_tdata)),
    .blk_i       (s_axis_tuser[0]),
    .floor_i     (floor),
    .down_free_i (core_free),
    .smp_valid_o (smp_valid),
    .smp_o       (smp)
  );

  hwpa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_valid_i (smp_valid),
    .smp_i       (smp),
    .floor_i     (floor),
    .blk_len_i   (blk_len),
    .free_o      (core_free),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.sum, res.peak, res.length};
  assign m_axis_tuser = res.polarity;

endmodule

// ===== verif/hwpa_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the half-wave period analyzer: predicts finished periods
// from accepted samples and checks each result transaction. Depends on hwpa_pkg.

package hwpa_scoreboard_pkg;

  import hwpa_pkg::*;

  class period_scoreboard;

    localparam logic [63:0] SumMax = 64'h003F_FFFF_FFFF_FFFF;

    logic [FloorW-1:0]  floor_q   = NoiseFloorRst;
    logic [BlkLenW-1:0] blk_len_q = BlockLengthRst;
    bit                 started   = 1'b0;
    cls_e               sign_q    = CLS_ZERO;
    logic [LenW-1:0]    len_q     = '0;
    logic [16:0]        peak_q    = '0;
    logic [SumW-1:0]    sum_q     = '0;
    res_t               periods_due[$];
    int                 mismatches = 0;

    function void write_register(cfg_reg_e idx, logic [31:0] value);
      case (idx)
        REG_NOISE_FLOOR:  floor_q   = value[FloorW-1:0];
        REG_BLOCK_LENGTH: blk_len_q = value[BlkLenW-1:0];
        default: ;
      endcase
    endfunction

    // Advance the period state by one sample; queue the period it closes.
    function void note_sample(logic signed [15:0] smp, logic blk);
      int          s;
      int          fl;
      int          m;
      cls_e        c;
      logic        split;
      res_t        p;
      logic [63:0] sq;
      s  = smp;
      fl = int'(floor_q);
      if (s > fl) c = CLS_POS;
      else if (s < -fl) c = CLS_NEG;
      else c = CLS_ZERO;
      m = (s < 0) ? -s : s;
      if (!started) begin
        started = 1'b1;
        sign_q  = c;
      end
      split = blk && (sign_q == CLS_ZERO) && (len_q >= blk_len_q);
      if (sign_q != c || split) begin
        p.polarity = sign_q;
        sign_q     = c;
        if (peak_q >= 17'(floor_q) || split) begin
          p.length = len_q;
          p.peak   = peak_q[15:0];
          p.sum    = sum_q;
          periods_due.push_back(p);
          // a split at block start keeps peak and energy
          if (c != p.polarity) begin
            peak_q = '0;
            sum_q  = '0;
          end
          len_q = '0;
        end
      end
      if (c != CLS_ZERO) begin
        sq = 64'(m) * 64'(m);
        if (17'(m) > peak_q) peak_q = 17'(m);
        if (64'(sum_q) > SumMax - sq) sum_q = SumMax[SumW-1:0];
        else sum_q = sum_q + sq[SumW-1:0];
      end else begin
        peak_q = {2'b00, floor_q};
      end
      if (len_q != '1) len_q = len_q + 1'b1;
    endfunction

    function void check_period(res_t got);
      res_t want;
      if (periods_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected period: pol %0d len %0d peak %0d sum %0d", $time,
                   $signed(got.polarity), got.length, got.peak, got.sum);
        return;
      end
      want = periods_due.pop_front();
      if (got.polarity !== want.polarity || got.length !== want.length ||
          got.peak !== want.peak || got.sum !== want.sum) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: period differs: exp pol %0d len %0d peak %0d sum %0d",
                   $time, $signed(want.polarity), want.length, want.peak, want.sum);
          $display("%0t:                 got pol %0d len %0d peak %0d sum %0d",
                   $time, $signed(got.polarity), got.length, got.peak, got.sum);
        end
      end
    endfunction

    function int outstanding();
      return periods_due.size();
    endfunction

  endclass

endpackage

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for half_wave_period_analyzer: directed and random sample streams
// under several register settings and idle patterns. Depends on hwpa_pkg, hwpa_scoreboard_pkg.

module testbench;

  import hwpa_pkg::*;
  import hwpa_scoreboard_pkg::*;

  localparam int CycleLimit = 300000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  period_scoreboard sb = new();

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int cur_floor    = 1;
  int cycles       = 0;

  half_wave_period_analyzer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // check results before noting the sample accepted on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_period('{polarity: cls_e'(m_axis_tuser), length: m_axis_tdata[23:0],
                          peak: m_axis_tdata[39:24], sum: m_axis_tdata[93:40]});
      if (s_axis_tvalid && s_axis_tready)
        sb.note_sample(s_axis_tdata, s_axis_tuser[0]);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_register(cfg_reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_register(idx, value);
    if (idx == REG_NOISE_FLOOR) cur_floor = int'(value[FloorW-1:0]);
  endtask

  task automatic send_sample(logic [15:0] value, logic blk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= blk;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending until every queued period has come out
  task automatic wait_for_periods();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample(cls_e c, int fl);
    int v;
    case (c)
      CLS_POS: v = (fl >= 32767) ? 0 : int'($urandom_range(32767, fl + 1));
      CLS_NEG: v = -int'($urandom_range(32768, fl + 1));
      default: v = int'($urandom_range(2 * fl)) - fl;
    endcase
    return v[15:0];
  endfunction

  // mostly runs of one class with random content, some raw noise
  task automatic run_phase(int n);
    int   left;
    int   run;
    cls_e c;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 15) begin
        send_sample(16'($urandom), 1'($urandom));
        left--;
      end else begin
        case ($urandom_range(2))
          0:       c = CLS_ZERO;
          1:       c = CLS_POS;
          default: c = CLS_NEG;
        endcase
        run = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(12, 1);
        repeat (run) begin
          send_sample(pick_sample(c, cur_floor), $urandom_range(7) == 0);
          left--;
        end
      end
      if ($urandom_range(199) == 0) wait_for_periods();
    end
  endtask

  initial begin
    int floors[6];
    int blk_lens[6];
    int tx_pct[4];
    int rx_pct[4];
    floors   = '{0, 32767, $urandom_range(2000, 1), $urandom_range(32767), 1,
                 $urandom_range(8000, 100)};
    blk_lens = '{1, 65535, $urandom_range(16, 2), 0, $urandom_range(40, 1), 1024};
    tx_pct   = '{0, 77, 0, 12};
    rx_pct   = '{0, 0, 77, 12};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero block length: the first sample splits an empty period
    write_register(REG_BLOCK_LENGTH, 32'd0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd0, 1'b1);
    wait_for_periods();

    write_register(REG_BLOCK_LENGTH, 32'd65535);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd2, 1'b0);
    send_sample(-16'sd2, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd100, 1'b0);
    wait_for_periods();

    // raised floor: the weak positive period merges into the next one
    write_register(REG_NOISE_FLOOR, 32'd5000);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd6000, 1'b0);
    wait_for_periods();

    write_register(REG_BLOCK_LENGTH, 32'd2);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd0, 1'b1);
    wait_for_periods();

    write_register(REG_NOISE_FLOOR, 32'd32767);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      wait_for_periods();
      write_register(REG_NOISE_FLOOR, 32'(floors[ph]));
      write_register(REG_BLOCK_LENGTH, 32'(blk_lens[ph]));
      tx_idle_pct  = tx_pct[ph % 4];
      rx_stall_pct = rx_pct[ph % 4];
      run_phase(130);
    end

    wait_for_periods();
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
